/* hw/rtl/dws_pkg.sv */
// Shared widths, register codes and result codes of the daily window scheduler.
package dws_pkg;

  localparam int unsigned MINUTE_W  = 11;
  localparam int unsigned SECOND_W  = 8;
  localparam int unsigned WINDOW_W  = 22;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned PROFILE_W = 2;

  localparam logic [MINUTE_W-1:0] MINS_PER_DAY    = 11'd1440;
  localparam logic [4:0]          HOURS_PER_DAY   = 5'd24;
  localparam logic [5:0]          MINS_PER_HOUR   = 6'd60;
  localparam logic [SECOND_W-1:0] SECS_PER_MIN    = 8'd60;
  localparam logic [MINUTE_W-1:0] FEED_TIME_RESET = 11'd1984;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MORNING_DAYBREAK = 3'd0,
    REG_EVENING_DAYBREAK = 3'd1,
    REG_DAY              = 3'd2,
    REG_NIGHT            = 3'd3,
    REG_FILTER           = 3'd4,
    REG_GAS              = 3'd5,
    REG_FEEDING_TIME     = 3'd6
  } cfg_reg_t;

  typedef enum logic [PROFILE_W-1:0] {
    PROFILE_DAYBREAK = 2'd0,
    PROFILE_DAY      = 2'd1,
    PROFILE_NIGHT    = 2'd2
  } profile_t;

endpackage

/* hw/rtl/dws_if.sv */
// Valid/ready channel interfaces for ticks, results and register writes.
interface dws_tick_if
  import dws_pkg::*;
#(
  parameter int unsigned DAY_KEY_BITS = 16
);
  logic                    valid;
  logic                    ready;
  logic [MINUTE_W-1:0]     minute_of_day;
  logic [SECOND_W-1:0]     second;
  logic [DAY_KEY_BITS-1:0] day_key;

  modport source (output valid, output minute_of_day, output second, output day_key,
                  input ready);
  modport sink   (input valid, input minute_of_day, input second, input day_key,
                  output ready);
endinterface

interface dws_result_if
  import dws_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 light_on;
  logic [PROFILE_W-1:0] light_profile;
  logic                 filter_on;
  logic                 gas_active;
  logic                 feed_due_now;
  logic                 feed_trigger;

  modport source (output valid, output light_on, output light_profile, output filter_on,
                  output gas_active, output feed_due_now, output feed_trigger,
                  input ready);
  modport sink   (input valid, input light_on, input light_profile, input filter_on,
                  input gas_active, input feed_due_now, input feed_trigger,
                  output ready);
endinterface

interface dws_cfg_if
  import dws_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [WINDOW_W-1:0]   data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

/* hw/rtl/daily_window_scheduler.sv */
// Daily window scheduler: six time windows and a once-per-day feeding trigger.
//
//   channel  dir  handshake       word
//   tick     in   valid / ready   minute_of_day, second, day_key
//   result   out  valid / ready   light_on, light_profile, filter_on, gas_active,
//                                 feed_due_now, feed_trigger
//   cfg      in   valid / ready   addr (register index), data
//
// One tick word is taken every cycle while the result register can advance.
// It is held in the input register, and its result is loaded into the result
// register, from which the sink takes it. The window compare and latch update
// are combinational, so a new word can enter as each result is loaded.
// Reset (rst, synchronous, active high) clears the valid flags, the feeding
// latch and the registers to their reset values; no clearing pass is needed.
// When the result is held by the sink, the input register still takes one
// more word; ready then falls until the result moves on.
module daily_window_scheduler
  import dws_pkg::*;
#(
  parameter int unsigned DAY_KEY_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  dws_tick_if.sink     tick,
  dws_result_if.source result,
  dws_cfg_if.sink      cfg
);

  // A packed time is [10:6] hour, [5:0] minute. It is valid when both the
  // hour and the minute are in range.
  function automatic logic time_ok(input logic [MINUTE_W-1:0] t);
    time_ok = (t[10:6] < HOURS_PER_DAY) && (t[5:0] < MINS_PER_HOUR);
  endfunction

  function automatic logic [MINUTE_W-1:0] time_minutes(input logic [MINUTE_W-1:0] t);
    time_minutes = ({6'd0, t[10:6]} * 11'd60) + {5'd0, t[5:0]};
  endfunction

  // A window holds start in [21:11] and end in [10:0]. When start is past end
  // the window wraps over midnight. An empty window or an invalid bound never
  // matches, and neither does a minute count beyond the day.
  function automatic logic in_window(input logic [MINUTE_W-1:0] now,
                                     input logic [WINDOW_W-1:0] w);
    logic [MINUTE_W-1:0] s_t;
    logic [MINUTE_W-1:0] e_t;
    logic [MINUTE_W-1:0] s;
    logic [MINUTE_W-1:0] e;
    s_t = w[21:11];
    e_t = w[10:0];
    s   = time_minutes(s_t);
    e   = time_minutes(e_t);
    if ((now >= MINS_PER_DAY) || !time_ok(s_t) || !time_ok(e_t) || (s == e)) begin
      in_window = 1'b0;
    end else if (s < e) begin
      in_window = (now >= s) && (now < e);
    end else begin
      in_window = (now >= s) || (now < e);
    end
  endfunction

  // Configuration registers.
  logic [WINDOW_W-1:0] morning_window;
  logic [WINDOW_W-1:0] evening_window;
  logic [WINDOW_W-1:0] day_window;
  logic [WINDOW_W-1:0] night_window;
  logic [WINDOW_W-1:0] filter_window;
  logic [WINDOW_W-1:0] gas_window;
  logic [MINUTE_W-1:0] feed_time;

  // Input register.
  logic                    tick_full;
  logic [MINUTE_W-1:0]     now_q;
  logic [SECOND_W-1:0]     sec_q;
  logic [DAY_KEY_BITS-1:0] key_q;

  // Feeding latch.
  logic                    fed_minute_valid;
  logic [MINUTE_W-1:0]     fed_minute;
  logic                    fed_day_valid;
  logic [DAY_KEY_BITS-1:0] fed_day;
  logic                    fed_minute_valid_next;
  logic                    fed_day_valid_next;
  logic                    latch_load;

  // Result register.
  logic     res_valid;
  logic     res_light;
  profile_t res_profile;
  logic     res_filter;
  logic     res_gas;
  logic     res_due;
  logic     res_trig;

  // Work on the word in the input register.
  logic                in_morning;
  logic                in_evening;
  logic                in_day;
  logic                in_night;
  logic                light_next;
  profile_t            profile_next;
  logic                due_next;
  logic                trig_next;
  logic [MINUTE_W-1:0] target;
  logic                key_known;
  logic                same_day;
  logic                advance;

  // The result register moves whenever it is empty or being taken.
  assign advance    = !res_valid || result.ready;
  assign tick.ready = !tick_full || advance;
  assign cfg.ready  = 1'b1;

  assign in_morning = in_window(now_q, morning_window);
  assign in_evening = in_window(now_q, evening_window);
  assign in_day     = in_window(now_q, day_window);
  assign in_night   = in_window(now_q, night_window);

  // Daybreak wins over day, day over night; with no light window the
  // profile reads as day.
  always_comb begin
    light_next   = 1'b1;
    profile_next = PROFILE_DAY;
    if (in_morning || in_evening) begin
      profile_next = PROFILE_DAYBREAK;
    end else if (in_day) begin
      profile_next = PROFILE_DAY;
    end else if (in_night) begin
      profile_next = PROFILE_NIGHT;
    end else begin
      light_next = 1'b0;
    end
  end

  assign target    = time_minutes(feed_time);
  assign due_next  = (sec_q < SECS_PER_MIN) && time_ok(feed_time) && (now_q == target);
  assign key_known = (key_q != '0);
  assign same_day  = fed_day_valid && (fed_day == key_q);

  // Once the current known day has fed, nothing changes. Otherwise a minute
  // that has moved off the latched one releases the minute latch, and a due
  // minute fires unless the day is unknown and it already fired for this minute.
  always_comb begin
    fed_minute_valid_next = fed_minute_valid;
    fed_day_valid_next    = fed_day_valid;
    latch_load            = 1'b0;
    trig_next             = 1'b0;
    if (key_known && same_day) begin
      trig_next = 1'b0;
    end else if (!due_next) begin
      if (fed_minute_valid && (now_q != fed_minute)) begin
        fed_minute_valid_next = 1'b0;
      end
    end else if (!(fed_minute_valid && (fed_minute == target) && (!key_known || same_day))) begin
      fed_minute_valid_next = 1'b1;
      fed_day_valid_next    = 1'b1;
      latch_load            = 1'b1;
      trig_next             = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      morning_window <= '0;
      evening_window <= '0;
      day_window     <= '0;
      night_window   <= '0;
      filter_window  <= '0;
      gas_window     <= '0;
      feed_time      <= FEED_TIME_RESET;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.addr))
        REG_MORNING_DAYBREAK: morning_window <= cfg.data;
        REG_EVENING_DAYBREAK: evening_window <= cfg.data;
        REG_DAY:              day_window     <= cfg.data;
        REG_NIGHT:            night_window   <= cfg.data;
        REG_FILTER:           filter_window  <= cfg.data;
        REG_GAS:              gas_window     <= cfg.data;
        REG_FEEDING_TIME:     feed_time      <= cfg.data[MINUTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_full <= 1'b0;
    end else if (tick.ready) begin
      tick_full <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      now_q <= tick.minute_of_day;
      sec_q <= tick.second;
      key_q <= tick.day_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fed_minute_valid <= 1'b0;
      fed_minute       <= '0;
      fed_day_valid    <= 1'b0;
      fed_day          <= '0;
    end else if (tick_full && advance) begin
      fed_minute_valid <= fed_minute_valid_next;
      fed_day_valid    <= fed_day_valid_next;
      if (latch_load) begin
        fed_minute <= target;
        fed_day    <= key_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= tick_full;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tick_full) begin
      res_light   <= light_next;
      res_profile <= profile_next;
      res_filter  <= in_window(now_q, filter_window);
      res_gas     <= in_window(now_q, gas_window);
      res_due     <= due_next;
      res_trig    <= trig_next;
    end
  end

  assign result.valid         = res_valid;
  assign result.light_on      = res_light;
  assign result.light_profile = res_profile;
  assign result.filter_on     = res_filter;
  assign result.gas_active    = res_gas;
  assign result.feed_due_now  = res_due;
  assign result.feed_trigger  = res_trig;

  // A trigger only ever fires on a due minute.
  a_trig_needs_due: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_trig |-> res_due)
    else $error("feed trigger without feeding due");

  // With the light off the profile must read as day.
  a_dark_is_day: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_light |-> res_profile == PROFILE_DAY)
    else $error("light off with a profile other than day");

  // A firing word leaves both latch halves set.
  a_fire_latches: assert property (@(posedge clk) disable iff (rst)
    tick_full && advance && trig_next |=> fed_minute_valid && fed_day_valid)
    else $error("feeding latch not set after trigger");

  // The fed day, once known, is only forgotten by reset.
  a_day_kept: assert property (@(posedge clk) disable iff (rst)
    fed_day_valid |=> fed_day_valid)
    else $error("fed day lost outside reset");

  // The input register can only be held while the result waits.
  a_hold_only_stalled: assert property (@(posedge clk) disable iff (rst)
    tick_full && !tick.ready |-> res_valid && !result.ready)
    else $error("input register held without a stalled result");

endmodule
